[rtl/efw_pkg.sv]
// Shared types, widths and the minimum-select helper for the
// earliest-free worker dispatch block. No dependencies.
`timescale 1ns / 1ps

package efw_pkg;

  // Worker pool size. The compare tree assumes a power of two.
  localparam int MaxWorkers = 16;
  localparam int IdxW       = $clog2(MaxWorkers);
  localparam int CountW     = 5;
  localparam int DurW       = 32;
  localparam int TimeW      = 48;
  localparam int WorkerIdW  = 4;
  localparam int OutDataW   = ((WorkerIdW + TimeW + 7) / 8) * 8;
  localparam int OutPadW    = OutDataW - WorkerIdW - TimeW;
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);

  localparam logic [CountW-1:0] WorkerCountReset = CountW'(MaxWorkers);

  // Job as classified by the front end
  typedef struct packed {
    logic            restart;
    logic [DurW-1:0] duration;
  } job_t;

  // One candidate of the minimum search
  typedef struct packed {
    logic             valid;
    logic [IdxW-1:0]  idx;
    logic [TimeW-1:0] free;
  } cand_t;

  // a always carries the lower worker numbers, so a tie keeps a
  function automatic cand_t pick_min(input cand_t a, input cand_t b);
    cand_t r;
    if (b.valid && (!a.valid || (b.free < a.free))) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

[rtl/efw_front.sv]
// Input stage: takes a transfer from the slave stream and classifies it
// into a job. Depends on efw_pkg.
`timescale 1ns / 1ps

module efw_front import efw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [DurW-1:0] s_axis_tdata,  // job_duration[31:0]
  input  logic            s_axis_tuser,  // restart
  output logic            push_o,
  output job_t            job_o,
  input  logic            q_ready_i
);

  logic valid_q, valid_d;
  job_t job_q, job_d;
  logic take;

  assign s_axis_tready = !valid_q || q_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign push_o        = valid_q && q_ready_i;
  assign job_o         = job_q;

  always_comb begin
    valid_d = valid_q;
    job_d   = job_q;
    if (take) begin
      valid_d      = 1'b1;
      job_d.restart  = s_axis_tuser;
      job_d.duration = s_axis_tdata;
    end else if (q_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

[rtl/efw_fifo.sv]
// Short job queue between front end and dispatch unit.
// Depends on efw_pkg.
`timescale 1ns / 1ps

module efw_fifo import efw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic ready_o,
  output logic head_valid_o,
  output job_t head_job_o,
  input  logic pop_i
);

  job_t mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;
  logic do_push, do_pop;

  assign ready_o      = (count_q != (QPtrW+1)'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

[rtl/efw_back.sv]
// Dispatch unit: free-time registers, minimum search, saturating update
// and the result register. Depends on efw_pkg.
`timescale 1ns / 1ps

module efw_back import efw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CountW-1:0]   worker_count_i,
  input  logic                head_valid_i,
  input  job_t                head_job_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // worker_id[3:0], start_time[51:4], zero pad
);

  logic [TimeW-1:0]     free_q [MaxWorkers];
  logic [TimeW-1:0]     free_d [MaxWorkers];
  logic [TimeW-1:0]     eff    [MaxWorkers];
  cand_t                node   [1:2*MaxWorkers-1];
  logic [CountW-1:0]    n_active;
  logic [IdxW-1:0]      best;
  logic [TimeW-1:0]     start;
  logic [TimeW:0]       sum_wide;
  logic [TimeW-1:0]     sum;
  logic                 disp;
  logic                 out_valid_q, out_valid_d;
  logic [WorkerIdW-1:0] worker_q;
  logic [TimeW-1:0]     start_q;

  // zero reads as one worker, anything above the pool as the whole pool
  always_comb begin
    if (worker_count_i == '0) begin
      n_active = CountW'(1);
    end else if (worker_count_i > CountW'(MaxWorkers)) begin
      n_active = CountW'(MaxWorkers);
    end else begin
      n_active = worker_count_i;
    end
  end

  assign disp  = head_valid_i && (!out_valid_q || m_axis_tready);
  assign pop_o = disp;

  // Restart sees every free time as zero
  always_comb begin
    for (int i = 0; i < MaxWorkers; i++) begin
      eff[i] = head_job_i.restart ? '0 : free_q[i];
    end
  end

  // Compare tree, leaves at MaxWorkers..2*MaxWorkers-1
  always_comb begin
    for (int i = 0; i < MaxWorkers; i++) begin
      node[MaxWorkers+i].valid = (CountW'(i) < n_active);
      node[MaxWorkers+i].idx   = IdxW'(i);
      node[MaxWorkers+i].free  = eff[i];
    end
    for (int k = MaxWorkers - 1; k >= 1; k--) begin
      node[k] = pick_min(node[2*k], node[2*k+1]);
    end
  end

  assign best     = node[1].idx;
  assign start    = node[1].free;
  assign sum_wide = {1'b0, start} + (TimeW+1)'(head_job_i.duration);
  assign sum      = sum_wide[TimeW] ? {TimeW{1'b1}} : sum_wide[TimeW-1:0];

  always_comb begin
    for (int i = 0; i < MaxWorkers; i++) begin
      free_d[i] = free_q[i];
      if (disp) begin
        if (IdxW'(i) == best) begin
          free_d[i] = sum;
        end else begin
          free_d[i] = eff[i];
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (disp) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxWorkers; i++) begin
        free_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      free_q      <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (disp) begin
      worker_q <= WorkerIdW'(best);
      start_q  <= start;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, start_q, worker_q};

  a_restart_worker0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (disp && head_job_i.restart) |=> (worker_q == '0 && start_q == '0))
    else $error("restart job not placed on worker 0 at time 0");

  a_free_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disp |=> (free_q[$past(best)] >= start_q))
    else $error("free time of dispatched worker fell below its start");

  a_result_from_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(head_valid_i))
    else $error("result appeared without a queued job");

endmodule

[rtl/earliest_free_worker_dispatch_core.sv]
// Earliest-free worker dispatch: places each job on the active worker that
// frees up first. A single transfer on the slave stream carries one job; one
// transfer on the master stream carries its result. Sustained rate is one job
// per clock while the master stream takes results; the limit is the dispatch
// loop of a 16-way compare tree, one 48-bit add and the free-time write-back.
// A job passes the front register, the queue and the result register. Ties go
// to the lowest worker number, free times saturate at 2^48-1, and a set
// restart flag clears all free times before that job. The user must write
// worker_count only while no job is in flight; the block does not enforce it.
// Depends on efw_pkg, efw_front, efw_fifo and efw_back.
`timescale 1ns / 1ps

module earliest_free_worker_dispatch_core import efw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DurW-1:0]     s_axis_tdata,   // job_duration[31:0]
  input  logic                s_axis_tuser,   // restart
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // worker_id[3:0], start_time[51:4], zero pad
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CountW-1:0]   cfg_data_i      // worker_count
);

  logic [CountW-1:0] worker_count_q;
  logic              push;
  job_t              push_job;
  logic              q_ready;
  logic              head_valid;
  job_t              head_job;
  logic              pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_count_q <= WorkerCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      worker_count_q <= cfg_data_i;
    end
  end

  efw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .push_o       (push),
    .job_o        (push_job),
    .q_ready_i    (q_ready)
  );

  efw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .ready_o     (q_ready),
    .head_valid_o(head_valid),
    .head_job_o  (head_job),
    .pop_i       (pop)
  );

  efw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .worker_count_i(worker_count_q),
    .head_valid_i  (head_valid),
    .head_job_i    (head_job),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[tb/tb_top.sv]
// Self-checking bench for earliest_free_worker_dispatch_core: a scoreboard class
// predicts worker and start time per job; tasks drive the job and count streams.
// Depends on efw_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
  import efw_pkg::*;

  typedef struct packed {
    logic [WorkerIdW-1:0] worker;
    logic [TimeW-1:0]     start;
  } placement_t;

  // Mirrors the worker pool: free times, active count and the placements still owed
  class worker_timeline;
    logic [TimeW-1:0]  free_at [MaxWorkers];
    logic [CountW-1:0] count_reg;
    placement_t        expected_q[$];
    int unsigned       mismatch_count;

    function new();
      foreach (free_at[i]) free_at[i] = '0;
      count_reg      = WorkerCountReset;
      mismatch_count = 0;
    endfunction

    function void set_count(logic [CountW-1:0] value);
      count_reg = value;
    endfunction

    function void place_job(logic restart, logic [DurW-1:0] duration);
      int          active;
      int          best;
      logic [TimeW:0] sum;
      placement_t  slot;
      active = (count_reg == 0) ? 1 : ((count_reg > MaxWorkers) ? MaxWorkers : count_reg);
      if (restart) begin
        foreach (free_at[i]) free_at[i] = '0;
      end
      best = 0;
      for (int i = 1; i < active; i++) begin
        if (free_at[i] < free_at[best]) best = i;
      end
      slot.worker = best[WorkerIdW-1:0];
      slot.start  = free_at[best];
      expected_q.push_back(slot);
      sum = {1'b0, free_at[best]} + {{(TimeW + 1 - DurW){1'b0}}, duration};
      // saturate at the top of the time range
      free_at[best] = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
    endfunction

    function void check_placement(logic [OutDataW-1:0] data);
      placement_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: tdata=%h", data);
        mismatch_count++;
        return;
      end
      want = expected_q.pop_front();
      if (data[WorkerIdW-1:0] !== want.worker) begin
        $error("worker_id: expected %0d, got %0d", want.worker, data[WorkerIdW-1:0]);
        mismatch_count++;
      end
      if (data[WorkerIdW +: TimeW] !== want.start) begin
        $error("start_time: expected %0d, got %0d", want.start, data[WorkerIdW +: TimeW]);
        mismatch_count++;
      end
      if (data[OutDataW-1:WorkerIdW+TimeW] !== '0) begin
        $error("pad: expected 0, got %h", data[OutDataW-1:WorkerIdW+TimeW]);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DurW-1:0]     s_axis_tdata  = '0;   // job_duration[31:0]
  logic                s_axis_tuser  = 1'b0; // restart
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // worker_id[3:0], start_time[51:4], zero pad
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CountW-1:0]   cfg_data_i    = '0;   // worker_count

  worker_timeline timeline;
  bit             quiet_gaps = 1'b0;
  bit             hold_req   = 1'b0;

  earliest_free_worker_dispatch_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Observe every transfer at the edge it completes on
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) timeline.set_count(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) timeline.place_job(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) timeline.check_placement(m_axis_tdata);
    end
  end

  // Result side: stall at random, or hold off for a long stretch on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = 300;
      end else begin
        stall = quiet_gaps ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic logic [DurW-1:0] draw_duration();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 3);
      3:       return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_job(input logic restart, input logic [DurW-1:0] duration);
    int gap;
    gap = quiet_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= duration;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (timeline.expected_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  // Only change the count once every job in flight has come out
  task automatic write_worker_count(input logic [CountW-1:0] value);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CountW-1:0] phase_counts [10];
    timeline = new();
    phase_counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd0, 5'd0, 5'd5, 5'd16};
    phase_counts[6] = CountW'($urandom_range(1, 16));
    phase_counts[7] = CountW'($urandom_range(0, 31));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ties from reset, zero and full durations, restart mid-batch
    send_job(1'b0, '0);
    send_job(1'b0, '0);
    send_job(1'b0, 32'd5);
    send_job(1'b0, 32'd3);
    send_job(1'b0, '1);
    for (int i = 0; i < 12; i++) send_job(1'b0, 32'd1 + i);
    send_job(1'b0, 32'd2);
    send_job(1'b1, 32'd7);
    send_job(1'b0, 32'd7);
    write_worker_count(5'd0);      // behaves as one worker
    send_job(1'b0, 32'd10);
    send_job(1'b0, 32'd10);
    write_worker_count(5'd31);     // clamps to the full pool, no clearing
    send_job(1'b0, 32'd1);
    send_job(1'b0, '1);
    send_job(1'b1, 32'h8000_0000);

    // Random batches under several counts
    for (int phase = 0; phase < 10; phase++) begin
      write_worker_count(phase_counts[phase]);
      quiet_gaps = (phase == 3) || (phase == 7);
      if (phase == 3) hold_req = 1'b1;
      for (int n = 0; n < 110; n++) begin
        send_job(((n == 0) && ($urandom_range(0, 1) == 1)) || ($urandom_range(0, 39) == 0),
                 draw_duration());
      end
    end

    // Stack full-length jobs back to back on a single worker
    write_worker_count(5'd1);
    quiet_gaps = 1'b1;
    send_job(1'b1, '1);
    for (int n = 0; n < 16; n++) send_job(1'b0, '1);
    send_job(1'b1, 32'd9);
    write_worker_count(5'd16);
    quiet_gaps = 1'b0;
    for (int n = 0; n < 20; n++) send_job(1'($urandom_range(0, 1)), draw_duration());

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if ((timeline.mismatch_count == 0) && (timeline.expected_q.size() == 0)) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
